>>> design/oaids_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_pkg: shared definitions for the ordered array block
// Sizes, request and status codes, and the structs passed between the
// control, the entry cells and the reduction tree.
// ----------------------------------------------------------------------------
package oaids_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TYPE_W = 3;
   localparam int STAT_W = 2;

   // Reduction tree: groups of eight cells, then one level over the groups.
   localparam int GRP    = 8;
   localparam int GRP_W  = 3;
   localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
   localparam int ISEL_W = IDX_W + GRP_W;

   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_SEARCH = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_READ   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

   // Broadcast to every cell; the operation flags are high only in the
   // cycle a transaction is accepted and has passed its checks.
   typedef struct packed {
      logic              append;
      logic              insert;
      logic              delete;
      logic              search;
      logic              read;
      logic [CNT_W-1:0]  count;
      logic [CNT_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
   } reduce_result_type;

endpackage
`default_nettype wire

>>> design/ordered_array_insert_delete_search.sv
`timescale 1ns / 1ps
`default_nettype none
// The response is registered after the cell match register and the
// registered group level of the two-level reduction tree; a new request
// is taken only once the last response has been loaded, which waits while
// a response is held for rsp_ready. All operations take the same time.
// Reset clears the entry count and the handshake state; entry contents are
// not cleared and only entries below the count are ever observed.
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search: bounded ordered array of entries
// A row of cells holds the entries and shifts them for insert and delete;
// search and read go through a match register and a reduction tree.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [oaids_pkg::TYPE_W-1:0]        req_type,
   input  wire  [oaids_pkg::CNT_W-1:0]         req_position,
   input  wire  signed [oaids_pkg::DATA_W-1:0] req_data_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [oaids_pkg::STAT_W-1:0]        rsp_status,
   output logic [oaids_pkg::IDX_W-1:0]         rsp_found_index,
   output logic signed [oaids_pkg::DATA_W-1:0] rsp_read_value,
   output logic [oaids_pkg::CNT_W-1:0]         rsp_entry_count
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_GROUP = 2'd1;
   localparam logic [1:0] S_OUT   = 2'd2;

   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic [oaids_pkg::CNT_W-1:0]   count_ff;
   logic [oaids_pkg::CNT_W-1:0]   count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   logic [oaids_pkg::STAT_W-1:0]  stat_ff;
   logic [oaids_pkg::STAT_W-1:0]  stat_in;
   logic                          srch_ff;
   logic                          srch_in;
   logic                          rdok_ff;
   logic                          rdok_in;
   logic [oaids_pkg::CNT_W-1:0]   rcnt_ff;

   logic [oaids_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [oaids_pkg::IDX_W-1:0]   rsp_index_ff;
   logic [oaids_pkg::DATA_W-1:0]  rsp_value_ff;
   logic [oaids_pkg::CNT_W-1:0]   rsp_count_ff;

   logic                          accept;
   logic                          full;
   logic                          load_rsp;
   oaids_pkg::cell_cmd_type       cmd;
   oaids_pkg::reduce_result_type  red;

   logic [oaids_pkg::DEPTH-1:0]                         cell_match;
   logic [oaids_pkg::DEPTH-1:0][oaids_pkg::DATA_W-1:0]  cell_values;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == oaids_pkg::CNT_W'(oaids_pkg::DEPTH));
   assign load_rsp  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Request checks and the count update happen in the accept cycle.
   always_comb begin
      cmd        = '0;
      cmd.count  = count_ff;
      cmd.pos    = req_position;
      cmd.value  = req_data_value;
      count_in   = count_ff;
      stat_in    = oaids_pkg::STAT_OK;
      srch_in    = 1'b0;
      rdok_in    = 1'b0;
      if (accept) begin
         case (req_type)
            oaids_pkg::REQ_CLEAR: begin
               count_in = '0;
            end
            oaids_pkg::REQ_APPEND: begin
               if (full) begin
                  stat_in = oaids_pkg::STAT_BAD;
               end else begin
                  cmd.append = 1'b1;
                  count_in   = count_ff + oaids_pkg::CNT_W'(1);
               end
            end
            oaids_pkg::REQ_INSERT: begin
               if (full || (req_position > count_ff)) begin
                  stat_in = oaids_pkg::STAT_BAD;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + oaids_pkg::CNT_W'(1);
               end
            end
            oaids_pkg::REQ_DELETE: begin
               if (req_position >= count_ff) begin
                  stat_in = oaids_pkg::STAT_BAD;
               end else begin
                  cmd.delete = 1'b1;
                  count_in   = count_ff - oaids_pkg::CNT_W'(1);
               end
            end
            oaids_pkg::REQ_SEARCH: begin
               cmd.search = 1'b1;
               srch_in    = 1'b1;
            end
            oaids_pkg::REQ_READ: begin
               if (req_position >= count_ff) begin
                  stat_in = oaids_pkg::STAT_BAD;
               end else begin
                  cmd.read = 1'b1;
                  rdok_in  = 1'b1;
               end
            end
            default: begin
               stat_in = oaids_pkg::STAT_BAD;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_GROUP;
            end
         end
         S_GROUP: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stat_ff <= stat_in;
         srch_ff <= srch_in;
         rdok_ff <= rdok_in;
         rcnt_ff <= count_in;
      end
      if (load_rsp) begin
         rsp_status_ff <= srch_ff ? (red.hit ? oaids_pkg::STAT_OK : oaids_pkg::STAT_MISS)
                                  : stat_ff;
         rsp_index_ff  <= (srch_ff && red.hit) ? red.index : '0;
         rsp_value_ff  <= rdok_ff ? red.value : '0;
         rsp_count_ff  <= rcnt_ff;
      end
   end

   for (genvar i = 0; i < oaids_pkg::DEPTH; i++) begin : g_cell
      logic [oaids_pkg::DATA_W-1:0] left_value;
      logic [oaids_pkg::DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_values[i-1];
      end
      if (i == oaids_pkg::DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_values[i+1];
      end

      oaids_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (oaids_pkg::IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_values[i]),
         .match       (cell_match[i])
      );
   end

   oaids_reduce u_reduce (
      .clock       (clock),
      .cell_match  (cell_match),
      .cell_values (cell_values),
      .result      (red)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire

>>> design/oaids_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_cell: one entry of the ordered array
// Holds one value, takes its neighbor's value on insert or delete, loads a
// new value, and registers a match flag for search and read.
// ----------------------------------------------------------------------------
module oaids_cell (
   input  wire                              clock,
   input  oaids_pkg::cell_cmd_type          cmd,
   input  wire  [oaids_pkg::IDX_W-1:0]      cell_index,
   input  wire  [oaids_pkg::DATA_W-1:0]     left_value,
   input  wire  [oaids_pkg::DATA_W-1:0]     right_value,
   output logic [oaids_pkg::DATA_W-1:0]     value,
   output logic                             match
);

   logic [oaids_pkg::DATA_W-1:0] value_ff;
   logic [oaids_pkg::DATA_W-1:0] value_in;
   logic                         match_ff;
   logic                         match_in;
   logic [oaids_pkg::CNT_W-1:0]  idx;

   assign idx = oaids_pkg::CNT_W'(cell_index);

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      if (cmd.append && (idx == cmd.count)) begin
         value_in = cmd.value;
      end
      if (cmd.insert) begin
         if (idx == cmd.pos) begin
            value_in = cmd.value;
         end else if (idx > cmd.pos) begin
            value_in = left_value;
         end
      end
      if (cmd.delete && (idx >= cmd.pos)) begin
         value_in = right_value;
      end
      // Cells at or above the count never report a search hit.
      if (cmd.search) begin
         match_in = (value_ff == cmd.value) && (idx < cmd.count);
      end
      if (cmd.read) begin
         match_in = (idx == cmd.pos);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule
`default_nettype wire

>>> design/oaids_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_reduce: match reduction tree
// Finds the lowest matching cell and the value of the selected cell, first
// inside registered groups of eight cells, then across the groups.
// ----------------------------------------------------------------------------
module oaids_reduce (
   input  wire                                             clock,
   input  wire  [oaids_pkg::DEPTH-1:0]                     cell_match,
   input  wire  [oaids_pkg::DEPTH-1:0][oaids_pkg::DATA_W-1:0] cell_values,
   output oaids_pkg::reduce_result_type                    result
);

   localparam int PAD = oaids_pkg::NGRP * oaids_pkg::GRP;

   logic [PAD-1:0]                         match_pad;
   logic [PAD-1:0][oaids_pkg::DATA_W-1:0]  value_pad;

   logic [oaids_pkg::NGRP-1:0]                         grp_hit_in;
   logic [oaids_pkg::NGRP-1:0][oaids_pkg::GRP_W-1:0]   grp_low_in;
   logic [oaids_pkg::NGRP-1:0][oaids_pkg::DATA_W-1:0]  grp_value_in;
   logic [oaids_pkg::NGRP-1:0]                         grp_hit_ff;
   logic [oaids_pkg::NGRP-1:0][oaids_pkg::GRP_W-1:0]   grp_low_ff;
   logic [oaids_pkg::NGRP-1:0][oaids_pkg::DATA_W-1:0]  grp_value_ff;

   logic [oaids_pkg::ISEL_W-1:0] sel_index;

   for (genvar c = 0; c < PAD; c++) begin : g_pad
      if (c < oaids_pkg::DEPTH) begin : g_real
         assign match_pad[c] = cell_match[c];
         assign value_pad[c] = cell_values[c];
      end else begin : g_fill
         assign match_pad[c] = 1'b0;
         assign value_pad[c] = '0;
      end
   end

   // Within a group: scan from the top so the lowest hit wins.
   always_comb begin
      for (int g = 0; g < oaids_pkg::NGRP; g++) begin
         grp_hit_in[g]   = 1'b0;
         grp_low_in[g]   = '0;
         grp_value_in[g] = '0;
         for (int k = oaids_pkg::GRP - 1; k >= 0; k--) begin
            if (match_pad[g * oaids_pkg::GRP + k]) begin
               grp_hit_in[g] = 1'b1;
               grp_low_in[g] = oaids_pkg::GRP_W'(k);
            end
            grp_value_in[g] = grp_value_in[g]
               | ({oaids_pkg::DATA_W{match_pad[g * oaids_pkg::GRP + k]}}
                  & value_pad[g * oaids_pkg::GRP + k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff   <= grp_hit_in;
      grp_low_ff   <= grp_low_in;
      grp_value_ff <= grp_value_in;
   end

   always_comb begin
      result.hit   = 1'b0;
      result.value = '0;
      sel_index    = '0;
      for (int g = oaids_pkg::NGRP - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            result.hit = 1'b1;
            sel_index  = (oaids_pkg::ISEL_W'(g) << oaids_pkg::GRP_W)
                         | oaids_pkg::ISEL_W'(grp_low_ff[g]);
         end
         result.value = result.value | grp_value_ff[g];
      end
      result.index = sel_index[oaids_pkg::IDX_W-1:0];
   end

endmodule
`default_nettype wire
